// ===== sv/clpi_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package clpi_pkg;

  // Payload and config widths
  localparam int COL_W    = 10;
  localparam int RING_W   = 8;
  localparam int SECT_W   = 9;
  localparam int SIDE_W   = 11;
  localparam int RCNT_W   = 9;
  localparam int SCNT_W   = 10;
  localparam int SCALE_W  = 24;
  localparam int CFG_IDX_W = 2;

  // Defaults for the top level parameters
  localparam int MAX_SIDE_DEF    = 1024;
  localparam int MAX_RINGS_DEF   = 256;
  localparam int MAX_SECTORS_DEF = 512;

  // Internal datapath widths
  localparam int DW   = 13;   // signed Q11.1 offset
  localparam int QW   = 23;   // squared distance
  localparam int PW   = 5;    // leading-one index of q
  localparam int MW   = 24;   // Q1.23 mantissa
  localparam int FW   = 16;   // log2 fraction bits
  localparam int LW   = PW + FW;
  localparam int CW   = 23;   // CORDIC x/y
  localparam int ZW   = 18;   // angle, turns * 65536
  localparam int NITER = 16;
  localparam int PRODW = SCALE_W + LW;
  localparam int VW   = 31;   // sector accumulator

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_SIDE   = 2'd0,
    REG_RING_COUNT   = 2'd1,
    REG_SECTOR_COUNT = 2'd2,
    REG_RING_SCALE   = 2'd3
  } cfg_reg_t;

  localparam logic [SIDE_W-1:0]  IMAGE_SIDE_RST   = 11'd256;
  localparam logic [RCNT_W-1:0]  RING_COUNT_RST   = 9'd64;
  localparam logic [SCNT_W-1:0]  SECTOR_COUNT_RST = 10'd128;
  localparam logic [SCALE_W-1:0] RING_SCALE_RST   = 24'd599186;

  // arctan(2^-i) in turns * 65536
  localparam logic [13:0] ATAN_TURNS [NITER] = '{
    14'd8192, 14'd4836, 14'd2555, 14'd1297, 14'd651, 14'd326, 14'd163, 14'd81,
    14'd41, 14'd20, 14'd10, 14'd5, 14'd3, 14'd1, 14'd1, 14'd0
  };

  localparam logic signed [ZW-1:0] QUARTER_TURN = 18'sd16384;

  // One word in the log / CORDIC section
  typedef struct packed {
    logic                 valid;
    logic [MW-1:0]        m;
    logic [FW-1:0]        frac;
    logic [PW-1:0]        p;
    logic                 nz;
    logic                 zero;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
  } iter_t;

endpackage

`default_nettype wire

// ===== sv/clpi_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Pixel position channel
interface clpi_pix_if;
  logic       valid;
  logic       ready;
  logic [9:0] pixel_col;
  logic [9:0] pixel_row;
  modport source (output valid, output pixel_col, output pixel_row, input ready);
  modport sink   (input valid, input pixel_col, input pixel_row, output ready);
endinterface

// Log-polar cell channel
interface clpi_cell_if;
  logic       valid;
  logic       ready;
  logic [7:0] ring_index;
  logic [8:0] sector_index;
  modport source (output valid, output ring_index, output sector_index, input ready);
  modport sink   (input valid, input ring_index, input sector_index, output ready);
endinterface

// Register write channel
interface clpi_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [23:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/cartesian_to_log_polar_index.sv =====
// Pixel word to cell word: offsets, fold, normalize, log2/CORDIC, products, round.
// Throughput: one word per cycle while the skid is empty; the 16 mantissa squarings
// of the log2 unit, one 24x24 multiply per stage, set the pipeline depth.
// A two-entry output (register plus skid) keeps in_ch.ready a pure register.
// Reset (rst_n low, synchronous) clears all valid bits and loads register defaults.
`timescale 1ns / 1ps
`default_nettype none

module cartesian_to_log_polar_index #(
  parameter int MAX_SIDE    = clpi_pkg::MAX_SIDE_DEF,
  parameter int MAX_RINGS   = clpi_pkg::MAX_RINGS_DEF,
  parameter int MAX_SECTORS = clpi_pkg::MAX_SECTORS_DEF
) (
  input  wire         clk,
  input  wire         rst_n,
  clpi_pix_if.sink    in_ch,
  clpi_cell_if.source out_ch,
  clpi_cfg_if.sink    cfg_ch
);
  import clpi_pkg::*;

  // ---------------- configuration registers ----------------
  logic [SIDE_W-1:0]  image_side_r;
  logic [RCNT_W-1:0]  ring_count_r;
  logic [SCNT_W-1:0]  sector_count_r;
  logic [SCALE_W-1:0] ring_scale_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_side_r   <= IMAGE_SIDE_RST;
      ring_count_r   <= RING_COUNT_RST;
      sector_count_r <= SECTOR_COUNT_RST;
      ring_scale_r   <= RING_SCALE_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_reg_t'(cfg_ch.index))
        REG_IMAGE_SIDE:   image_side_r   <= cfg_ch.data[SIDE_W-1:0];
        REG_RING_COUNT:   ring_count_r   <= cfg_ch.data[RCNT_W-1:0];
        REG_SECTOR_COUNT: sector_count_r <= cfg_ch.data[SCNT_W-1:0];
        REG_RING_SCALE:   ring_scale_r   <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // Effective sizes after the build-time limits
  logic [SIDE_W-1:0] s;
  logic [RCNT_W-1:0] rc;
  logic [SCNT_W-1:0] sc;
  assign s  = (image_side_r > MAX_SIDE) ? SIDE_W'(MAX_SIDE) : image_side_r;
  assign rc = (ring_count_r > MAX_RINGS) ? RCNT_W'(MAX_RINGS) : ring_count_r;
  assign sc = (sector_count_r > MAX_SECTORS) ? SCNT_W'(MAX_SECTORS) : sector_count_r;

  // Whole pipeline advances unless the skid holds a word
  logic en;
  logic skid_v_r;
  assign en          = !skid_v_r;
  assign in_ch.ready = en;

  // ---------------- stage 1: offsets and squares ----------------
  logic signed [DW-1:0]   dx, dy;
  logic signed [2*DW-1:0] dx2, dy2;
  assign dx  = $signed({2'b00, in_ch.pixel_col, 1'b0}) - $signed({2'b00, s});
  assign dy  = $signed({2'b00, in_ch.pixel_row, 1'b0}) - $signed({2'b00, s});
  assign dx2 = dx * dx;
  assign dy2 = dy * dy;

  logic                 s1_v_r;
  logic signed [DW-1:0] s1_dx_r, s1_dy_r;
  logic [QW-1:0]        s1_dx2_r, s1_dy2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s1_v_r <= 1'b0;
    else if (en) s1_v_r <= in_ch.valid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s1_dx_r  <= dx;
      s1_dy_r  <= dy;
      s1_dx2_r <= dx2[QW-1:0];
      s1_dy2_r <= dy2[QW-1:0];
    end
  end

  // ---------------- stage 2: distance clamp, quadrant fold ----------------
  logic [QW-1:0]          q_sum, q_clamp;
  logic [2*SIDE_W-1:0]    ss, s2m2;
  logic [SIDE_W-1:0]      sm2;
  logic signed [CW-1:0]   xa, ya, xr, yr;
  logic signed [ZW-1:0]   zr;

  assign q_sum = s1_dx2_r + s1_dy2_r;
  assign ss    = s * s;
  assign sm2   = (s >= SIDE_W'(2)) ? (s - SIDE_W'(2)) : '0;
  assign s2m2  = sm2 * sm2;
  assign q_clamp = ({1'b0, q_sum} >= {1'b0, ss}) ? QW'(s2m2) : q_sum;

  assign xa = {{(CW-DW-8){s1_dx_r[DW-1]}}, s1_dx_r, 8'b0};
  assign ya = {{(CW-DW-8){s1_dy_r[DW-1]}}, s1_dy_r, 8'b0};

  always_comb begin
    xr = xa;
    yr = ya;
    zr = '0;
    if (xa < 0) begin
      if (ya >= 0) begin
        xr = ya;
        yr = -xa;
        zr = QUARTER_TURN;
      end else begin
        xr = -ya;
        yr = xa;
        zr = -QUARTER_TURN;
      end
    end
  end

  logic                 s2_v_r, s2_zero_r;
  logic [QW-1:0]        s2_q_r;
  logic signed [CW-1:0] s2_x_r, s2_y_r;
  logic signed [ZW-1:0] s2_z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s2_v_r <= 1'b0;
    else if (en) s2_v_r <= s1_v_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s2_q_r    <= q_clamp;
      s2_x_r    <= xr;
      s2_y_r    <= yr;
      s2_z_r    <= zr;
      s2_zero_r <= (s1_dx_r == 0) && (s1_dy_r == 0);
    end
  end

  // ---------------- stage 3: leading one and normalize ----------------
  logic [PW-1:0] lead;
  always_comb begin
    lead = '0;
    for (int b = 0; b < QW; b++) begin
      if (s2_q_r[b]) lead = PW'(b);
    end
  end

  logic [MW-1:0] m_norm;
  assign m_norm = {1'b0, s2_q_r} << (PW'(MW - 1) - lead);

  iter_t it_r [NITER+1];
  iter_t it0;

  always_comb begin
    it0.valid = s2_v_r;
    it0.m     = m_norm;
    it0.frac  = '0;
    it0.p     = lead;
    it0.nz    = (s2_q_r != 0);
    it0.zero  = s2_zero_r;
    it0.x     = s2_x_r;
    it0.y     = s2_y_r;
    it0.z     = s2_z_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) it_r[0].valid <= 1'b0;
    else if (en) it_r[0].valid <= it0.valid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      it_r[0].m    <= it0.m;
      it_r[0].frac <= it0.frac;
      it_r[0].p    <= it0.p;
      it_r[0].nz   <= it0.nz;
      it_r[0].zero <= it0.zero;
      it_r[0].x    <= it0.x;
      it_r[0].y    <= it0.y;
      it_r[0].z    <= it0.z;
    end
  end

  // ---------------- 16 stages: one log2 bit and one CORDIC step each ----------------
  for (genvar i = 0; i < NITER; i++) begin : g_iter
    logic [2*MW-1:0]      sq;
    logic signed [CW-1:0] xs, ys;
    logic signed [ZW-1:0] at;
    iter_t                nxt;

    assign sq = it_r[i].m * it_r[i].m;
    assign xs = it_r[i].x >>> i;
    assign ys = it_r[i].y >>> i;
    assign at = $signed({{(ZW-14){1'b0}}, ATAN_TURNS[i]});

    always_comb begin
      nxt = it_r[i];
      // squared mantissa >= 2: halve and set this fraction bit
      if (sq[2*MW-1]) begin
        nxt.m = sq[2*MW-1:MW];
        nxt.frac[FW-1-i] = 1'b1;
      end else begin
        nxt.m = sq[2*MW-2:MW-1];
      end
      // vectoring rotation toward the x axis
      if (it_r[i].y > 0) begin
        nxt.x = it_r[i].x + ys;
        nxt.y = it_r[i].y - xs;
        nxt.z = it_r[i].z + at;
      end else begin
        nxt.x = it_r[i].x - ys;
        nxt.y = it_r[i].y + xs;
        nxt.z = it_r[i].z - at;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) it_r[i+1].valid <= 1'b0;
      else if (en) it_r[i+1].valid <= nxt.valid;
    end
    always_ff @(posedge clk) begin
      if (en) begin
        it_r[i+1].m    <= nxt.m;
        it_r[i+1].frac <= nxt.frac;
        it_r[i+1].p    <= nxt.p;
        it_r[i+1].nz   <= nxt.nz;
        it_r[i+1].zero <= nxt.zero;
        it_r[i+1].x    <= nxt.x;
        it_r[i+1].y    <= nxt.y;
        it_r[i+1].z    <= nxt.z;
      end
    end
  end

  // ---------------- stage 4: ring and sector products ----------------
  localparam logic [LW-1:0] TWO_Q16 = LW'(131072);

  iter_t                fin;
  logic [LW-1:0]        lq, lsub;
  logic                 ring_ok;
  logic [PRODW-1:0]     prod;
  logic signed [ZW-1:0] t;
  logic signed [VW-1:0] v;

  assign fin     = it_r[NITER];
  assign lq      = {fin.p, fin.frac};
  assign ring_ok = fin.nz && (lq > TWO_Q16);
  assign lsub    = lq - TWO_Q16;
  assign prod    = ring_ok ? (ring_scale_r * lsub) : '0;
  assign t       = fin.zero ? '0 : fin.z;
  // both factors sign-extended to the accumulator width before the multiply
  assign v       = $signed(VW'(t)) * $signed(VW'({1'b0, sc}))
                 + $signed({{(VW-SCNT_W-15){1'b0}}, sc[SCNT_W-1:1], 16'b0})
                 + $signed(VW'(32768));

  logic                 s4_v_r;
  logic [PRODW-1:0]     s4_prod_r;
  logic signed [VW-1:0] s4_v_acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s4_v_r <= 1'b0;
    else if (en) s4_v_r <= fin.valid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s4_prod_r  <= prod;
      s4_v_acc_r <= v;
    end
  end

  // ---------------- stage 5: round, saturate, wrap ----------------
  localparam int RW = PRODW + 1 - 33;

  logic [PRODW:0]          rsum;
  logic [RW-1:0]           ring_w;
  logic [RING_W-1:0]       ring_o;
  logic signed [VW-17:0]   sect_w;
  logic [SECT_W-1:0]       sect_o;

  assign rsum   = {1'b0, s4_prod_r} + (PRODW+1)'(64'h1_0000_0000);
  assign ring_w = rsum[PRODW:33];
  assign sect_w = s4_v_acc_r[VW-1:16];

  always_comb begin
    ring_o = '0;
    if (rc != 0) begin
      if (ring_w > RW'(rc - RCNT_W'(1))) begin
        ring_o = (rc > RCNT_W'(256)) ? '1 : RING_W'(rc - RCNT_W'(1));
      end else if (ring_w > RW'(255)) begin
        ring_o = '1;
      end else begin
        ring_o = ring_w[RING_W-1:0];
      end
    end
  end

  always_comb begin
    sect_o = '0;
    if (sc != 0) begin
      if (sect_w >= $signed({{(VW-16-SCNT_W){1'b0}}, sc})) begin
        sect_o = SECT_W'(sect_w - $signed({{(VW-16-SCNT_W){1'b0}}, sc}));
      end else if (sect_w < 0) begin
        sect_o = SECT_W'(sect_w + $signed({{(VW-16-SCNT_W){1'b0}}, sc}));
      end else begin
        sect_o = SECT_W'(sect_w);
      end
    end
  end

  logic                o_v_r;
  logic [RING_W-1:0]   o_ring_r;
  logic [SECT_W-1:0]   o_sect_r;

  always_ff @(posedge clk) begin
    if (!rst_n) o_v_r <= 1'b0;
    else if (en) o_v_r <= s4_v_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      o_ring_r <= ring_o;
      o_sect_r <= sect_o;
    end
  end

  // ---------------- output skid ----------------
  logic              skid_v_nxt;
  logic [RING_W-1:0] skid_ring_r;
  logic [SECT_W-1:0] skid_sect_r;

  always_comb begin
    skid_v_nxt = skid_v_r;
    if (skid_v_r) begin
      if (out_ch.ready) skid_v_nxt = 1'b0;
    end else if (o_v_r && !out_ch.ready) begin
      skid_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) skid_v_r <= 1'b0;
    else skid_v_r <= skid_v_nxt;
  end
  always_ff @(posedge clk) begin
    if (!skid_v_r) begin
      skid_ring_r <= o_ring_r;
      skid_sect_r <= o_sect_r;
    end
  end

  assign out_ch.valid        = skid_v_r || o_v_r;
  assign out_ch.ring_index   = skid_v_r ? skid_ring_r : o_ring_r;
  assign out_ch.sector_index = skid_v_r ? skid_sect_r : o_sect_r;

endmodule

`default_nettype wire

// ===== sv/clpi_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module clpi_checker (
  input wire       clk,
  input wire       rst_n,
  input wire       in_valid,
  input wire       in_ready,
  input wire       out_valid,
  input wire       out_ready,
  input wire [7:0] ring_index,
  input wire [8:0] sector_index
);

  // Words inside the block: 21 stages plus the skid entry
  localparam int DEPTH = 22;

  logic [4:0] cnt_r;
  logic [4:0] cnt_nxt;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_comb begin
    cnt_nxt = cnt_r;
    if (in_acc && !out_acc) cnt_nxt = cnt_r + 5'd1;
    else if (!in_acc && out_acc) cnt_nxt = cnt_r - 5'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cnt_r <= '0;
    else cnt_r <= cnt_nxt;
  end

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(ring_index) && $stable(sector_index))
    else $error("result word changed while stalled");

  // Input is only held off while a result is waiting
  a_ready_low: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with no result pending");

  // No result without an accepted pixel behind it
  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc |-> cnt_r != 5'd0)
    else $error("result word without a pixel word");

  // Nothing lost: the block never holds more than its stages plus the skid entry
  a_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 5'(DEPTH))
    else $error("more words in flight than pipeline stages");

endmodule

bind cartesian_to_log_polar_index clpi_checker u_clpi_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .ring_index   (out_ch.ring_index),
  .sector_index (out_ch.sector_index)
);

`default_nettype wire

// ===== tb/cartesian_to_log_polar_index_checker.sv =====
`timescale 1ns / 1ps

module cartesian_to_log_polar_index_checker #(
  parameter int MAX_SIDE    = clpi_pkg::MAX_SIDE_DEF,
  parameter int MAX_RINGS   = clpi_pkg::MAX_RINGS_DEF,
  parameter int MAX_SECTORS = clpi_pkg::MAX_SECTORS_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  clpi_pix_if   pix,
  clpi_cell_if  res,
  clpi_cfg_if   cfg,
  output int    errors,
  output int    pending
);
  import clpi_pkg::*;

  typedef struct packed {
    logic [RING_W-1:0] ring;
    logic [SECT_W-1:0] sector;
  } cell_t;

  // arctan(2^-i) in turns * 65536
  localparam longint ATAN_TAB [16] = '{
    8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10, 5, 3, 1, 1, 0
  };

  cell_t cells_due[$];

  logic [SIDE_W-1:0]  side_r;
  logic [RCNT_W-1:0]  rings_r;
  logic [SCNT_W-1:0]  sectors_r;
  logic [SCALE_W-1:0] scale_r;

  function automatic longint unsigned log2_q16(longint unsigned q);
    int p;
    longint unsigned m;
    longint unsigned frac;
    p = 0;
    frac = 0;
    while (p < 39 && (q >> (p + 1)) != 0) p++;
    m = (p <= 23) ? (q << (23 - p)) : (q >> (p - 23));
    for (int b = 15; b >= 0; b--) begin
      m = (m * m) >> 23;
      if (m >= (64'd1 << 24)) begin
        m = m >> 1;
        frac |= 64'd1 << b;
      end
    end
    return longint'(p) * 65536 + frac;
  endfunction

  // vectoring CORDIC, angle in turns * 65536
  function automatic longint cordic_turns(longint x, longint y);
    longint z, t, xs, ys;
    z = 0;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = 16384;
      end else begin
        t = x; x = -y; y = t; z = -16384;
      end
    end
    for (int i = 0; i < 16; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x = x + ys; y = y - xs; z += ATAN_TAB[i];
      end else begin
        x = x - ys; y = y + xs; z -= ATAN_TAB[i];
      end
    end
    return z;
  endfunction

  function automatic cell_t locate_cell(logic [COL_W-1:0] col, logic [COL_W-1:0] row);
    longint s, rc, sc, dx, dy, t, v, sector;
    longint unsigned q, m2, lq, prod, ring;
    cell_t c;
    s  = (side_r < MAX_SIDE) ? longint'(side_r) : MAX_SIDE;
    rc = (rings_r < MAX_RINGS) ? longint'(rings_r) : MAX_RINGS;
    sc = (sectors_r < MAX_SECTORS) ? longint'(sectors_r) : MAX_SECTORS;
    dx = 2 * longint'(col) - s;
    dy = 2 * longint'(row) - s;
    q = dx * dx + dy * dy;
    ring = 0;
    sector = 0;
    // clamp just inside the image radius
    if (q >= s * s) begin
      m2 = (s >= 2) ? s - 2 : 0;
      q = m2 * m2;
    end
    if (q != 0) begin
      lq = log2_q16(q);
      if (lq > 131072) begin
        prod = longint'(scale_r) * (lq - 131072);
        ring = (prod + (64'd1 << 32)) >> 33;
      end
    end
    if (rc == 0) ring = 0;
    else if (ring > rc - 1) ring = rc - 1;
    if (ring > 255) ring = 255;
    if (sc != 0) begin
      t = (dx == 0 && dy == 0) ? 0 : cordic_turns(dx * 256, dy * 256);
      v = t * sc + (sc / 2) * 65536 + 32768;
      sector = v >>> 16;
      while (sector >= sc) sector -= sc;
      while (sector < 0) sector += sc;
    end
    c.ring   = ring[RING_W-1:0];
    c.sector = sector[SECT_W-1:0];
    return c;
  endfunction

  task automatic report(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  initial begin
    errors = 0;
    pending = 0;
  end

  // register copy, predict on input words, compare on output words
  always @(posedge clk) begin
    cell_t want;
    if (!rst_n) begin
      side_r    <= IMAGE_SIDE_RST;
      rings_r   <= RING_COUNT_RST;
      sectors_r <= SECTOR_COUNT_RST;
      scale_r   <= RING_SCALE_RST;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg_reg_t'(cfg.index))
          REG_IMAGE_SIDE:   side_r    <= cfg.data[SIDE_W-1:0];
          REG_RING_COUNT:   rings_r   <= cfg.data[RCNT_W-1:0];
          REG_SECTOR_COUNT: sectors_r <= cfg.data[SCNT_W-1:0];
          REG_RING_SCALE:   scale_r   <= cfg.data[SCALE_W-1:0];
          default: ;
        endcase
      end
      if (pix.valid && pix.ready)
        cells_due = {cells_due, locate_cell(pix.pixel_col, pix.pixel_row)};
      if (res.valid && res.ready) begin
        if (cells_due.size() == 0) begin
          report("unexpected word ring", int'(res.ring_index), -1);
        end else begin
          want = cells_due.pop_front();
          if (res.ring_index !== want.ring)
            report("ring", int'(res.ring_index), int'(want.ring));
          if (res.sector_index !== want.sector)
            report("sector", int'(res.sector_index), int'(want.sector));
        end
      end
    end
    pending = cells_due.size();
  end

endmodule

// ===== tb/cartesian_to_log_polar_index_tb.sv =====
`timescale 1ns / 1ps

module cartesian_to_log_polar_index_tb;
  import clpi_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int DRAIN = 40;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   errors;
  int   pending;
  int   cycles = 0;
  bit   no_idle = 0;
  bit   long_hold = 0;
  int   cur_side = 256;

  clpi_pix_if  pix_ch ();
  clpi_cell_if cell_ch ();
  clpi_cfg_if  cfg_ch ();

  always #1 clk = ~clk;

  cartesian_to_log_polar_index u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (pix_ch),
    .out_ch (cell_ch),
    .cfg_ch (cfg_ch)
  );

  cartesian_to_log_polar_index_checker u_chk (
    .clk     (clk),
    .rst_n   (rst_n),
    .pix     (pix_ch),
    .res     (cell_ch),
    .cfg     (cfg_ch),
    .errors  (errors),
    .pending (pending)
  );

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // receiver: random gaps, one long hold-off when asked
  initial begin
    int gap;
    cell_ch.ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (long_hold) begin
        cell_ch.ready <= 1'b0;
        repeat (300) @(posedge clk);
        long_hold = 0;
      end
      gap = no_idle ? 0 : $urandom_range(13, 0);
      if (gap > 0) begin
        cell_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      cell_ch.ready <= 1'b1;
      do @(posedge clk); while (!(cell_ch.valid && cell_ch.ready));
    end
  end

  task automatic send_pixel(logic [9:0] col, logic [9:0] row);
    int gap;
    gap = no_idle ? 0 : $urandom_range(13, 0);
    if (gap > 0) begin
      pix_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_ch.valid     <= 1'b1;
    pix_ch.pixel_col <= col;
    pix_ch.pixel_row <= row;
    do @(posedge clk); while (!pix_ch.ready);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [23:0] value);
    pix_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (30) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    if (idx == REG_IMAGE_SIDE) cur_side = int'(value[10:0]);
  endtask

  // one setting of all four registers, scale fitted to side and rings
  task automatic set_geometry(int side, int rings, int sectors);
    real rad;
    longint sc;
    write_reg(REG_IMAGE_SIDE, 24'(side));
    write_reg(REG_RING_COUNT, 24'(rings));
    write_reg(REG_SECTOR_COUNT, 24'(sectors));
    rad = ((side > MAX_SIDE_DEF) ? MAX_SIDE_DEF : side) / 2.0;
    sc = (rad > 1.0) ? longint'($rtoi(rings * 65536.0 * $ln(2.0) / $ln(rad))) : 0;
    if (sc > 24'hFFFFFF) sc = 24'hFFFFFF;
    write_reg(REG_RING_SCALE, 24'(sc));
  endtask

  // mostly pixels inside the image, some anywhere
  task automatic random_pixels(int n);
    int lim;
    for (int i = 0; i < n; i++) begin
      lim = (cur_side > 1 && cur_side <= 1024) ? cur_side - 1 : 1023;
      if ($urandom_range(9, 0) < 8)
        send_pixel(10'($urandom_range(lim, 0)), 10'($urandom_range(lim, 0)));
      else
        send_pixel(10'($urandom()), 10'($urandom()));
    end
  endtask

  initial begin
    pix_ch.valid = 1'b0;
    pix_ch.pixel_col = '0;
    pix_ch.pixel_row = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_IMAGE_SIDE;
    cfg_ch.data = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: center, axes, corners, near center, outside, at reset values
    send_pixel(128, 128);
    send_pixel(129, 128);
    send_pixel(128, 129);
    send_pixel(127, 128);
    send_pixel(128, 127);
    send_pixel(255, 128);
    send_pixel(0, 128);
    send_pixel(128, 255);
    send_pixel(128, 0);
    send_pixel(0, 0);
    send_pixel(255, 255);
    send_pixel(0, 255);
    send_pixel(255, 0);
    send_pixel(1023, 1023);
    send_pixel(1023, 0);
    send_pixel(0, 1023);
    send_pixel(10'h2AA, 10'h155);
    send_pixel(10'h155, 10'h2AA);
    send_pixel(200, 56);
    send_pixel(56, 200);

    // fill the pipeline against a stalled output
    long_hold = 1;
    no_idle = 1;
    random_pixels(60);
    no_idle = 0;
    random_pixels(40);

    // extremes of the geometry
    set_geometry(1024, 256, 512);
    random_pixels(40);
    set_geometry(2, 1, 1);
    random_pixels(15);
    set_geometry(3, 2, 2);
    random_pixels(15);
    set_geometry(2047, 511, 1023);
    random_pixels(30);
    set_geometry(1, 0, 0);
    random_pixels(10);
    set_geometry(0, 64, 3);
    random_pixels(10);
    set_geometry(5, 256, 511);
    random_pixels(20);

    // raw scale extremes
    set_geometry(64, 16, 7);
    write_reg(REG_RING_SCALE, 24'hFFFFFF);
    random_pixels(20);
    write_reg(REG_RING_SCALE, 24'h000000);
    random_pixels(10);

    // random settings
    for (int k = 0; k < 6; k++) begin
      set_geometry($urandom_range(1024, 2), $urandom_range(256, 1), $urandom_range(512, 1));
      write_reg(REG_RING_SCALE, 24'($urandom()));
      no_idle = ($urandom_range(3, 0) == 0);
      random_pixels(20);
      set_geometry(cur_side, $urandom_range(256, 1), $urandom_range(512, 1));
      random_pixels(20);
    end
    no_idle = 0;

    pix_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN) @(posedge clk);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== cartesian_to_log_polar_index.f =====
sv/clpi_pkg.sv
sv/clpi_if.sv
sv/cartesian_to_log_polar_index.sv
sv/clpi_checker.sv
tb/cartesian_to_log_polar_index_checker.sv
tb/cartesian_to_log_polar_index_tb.sv
